// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the deadband change tracker.
// Both macros sample on aclk; the first is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define ADBCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define ADBCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/adbct_pkg.sv =====
// Shared types and constants of the deadband change tracker.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package adbct_pkg;

    localparam int CH_W      = 5;
    localparam int VAL_W     = 16;
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 2;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Results per service word, and the counter that tracks them.
    localparam int OUT_CAP = 16;
    localparam int CNT_W   = 4;

    // Channels that exist in hardware: 0..18 minus the reserved 12..14.
    localparam logic [31:0] CH_ALLOW_MASK = 32'h0007_8FFF;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SERVICE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BAND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RELOAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MASK     = 2'd3;

    // Output register source select.
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_READ = 2'd1;
    localparam logic [1:0] SEL_SCAN = 2'd2;

    typedef struct packed {
        logic            smp_upd;
        logic            scan;
        logic [CH_W-1:0] scan_ch;
        logic            out_load;
        logic [1:0]      out_sel;
        logic            out_last;
        logic            flag_clr;
    } adbct_cmd_t;

    typedef struct packed {
        logic any_hit;
        logic cur_hit;
        logic more_hit;
        logic out_free;
    } adbct_sts_t;

endpackage

// ===== rtl/adbct_ctrl.sv =====
// Controller of the deadband change tracker: decodes input words and walks
// the channel scan of a service word. Depends on adbct_pkg.
`timescale 1ns / 1ps

module adbct_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [adbct_pkg::FUNC_W-1:0] s_func,
    input  adbct_pkg::adbct_sts_t     sts,
    output adbct_pkg::adbct_cmd_t     cmd
);
    import adbct_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic            state_reg, state_next;
    logic [CH_W-1:0] scan_ch_reg, scan_ch_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            last_hit;

    always_comb begin
        state_next   = state_reg;
        scan_ch_next = scan_ch_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.scan_ch  = scan_ch_reg;
        last_hit     = (cnt_reg == CNT_W'(OUT_CAP - 1)) || !sts.more_hit;
        case (state_reg)
            ST_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    case (s_func)
                        FUNC_SAMPLE: begin
                            cmd.smp_upd = 1'b1;
                        end
                        FUNC_READ: begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = SEL_READ;
                            cmd.out_last = 1'b1;
                        end
                        FUNC_SERVICE: begin
                            if (sts.any_hit) begin
                                state_next   = ST_SCAN;
                                scan_ch_next = '0;
                                cnt_next     = '0;
                            end else begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = SEL_NONE;
                                cmd.out_last = 1'b1;
                            end
                        end
                        default: begin
                            // unused code: drop the word
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.cur_hit) begin
                    // hold on a flagged channel until the output slot frees
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_SCAN;
                        cmd.out_last = last_hit;
                        cmd.flag_clr = 1'b1;
                        cnt_next     = cnt_reg + 1'b1;
                        scan_ch_next = scan_ch_reg + 1'b1;
                        if (last_hit) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    scan_ch_next = scan_ch_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scan_ch_reg <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            scan_ch_reg <= scan_ch_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// ===== rtl/adbct_dp.sv =====
// Datapath of the deadband change tracker: configuration registers, per-channel
// stores, deadband compare and the output register. Depends on adbct_pkg.
`timescale 1ns / 1ps

module adbct_dp #(
    parameter int NUM_CHANNELS = 19,
    parameter int VALUE_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [adbct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adbct_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [adbct_pkg::S_TDATA_W-1:0] s_tdata,
    input  adbct_pkg::adbct_cmd_t          cmd,
    output adbct_pkg::adbct_sts_t          sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [adbct_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [adbct_pkg::STAT_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import adbct_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [VAL_W-1:0] db_reg, idle_db_reg, idle_reload_reg;
    logic [CFG_W-1:0] mask_reg;

    logic [VALUE_BITS-1:0] pub_reg [NUM_CHANNELS];
    logic [VAL_W-1:0]      idle_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] flag_reg;

    logic [CH_W-1:0]       s_ch;
    logic [VAL_W-1:0]      s_val;
    logic                  s_port;
    logic [VALUE_BITS-1:0] smp;
    logic [31:0]           mask_ext, hit_ext;
    logic [NUM_CHANNELS-1:0] hit;
    logic                  ch_ok;
    logic [CH_W-1:0]       addr_ch;
    logic [IDX_W-1:0]      addr;
    logic [VALUE_BITS-1:0] pub_rd, diff;
    logic [VAL_W-1:0]      idle_rd, band;
    logic                  publish;

    logic                  m_valid_reg, m_last_reg;
    logic [CH_W-1:0]       m_ch_reg, m_ch_next;
    logic [VAL_W-1:0]      m_val_reg, m_val_next;
    logic [STAT_W-1:0]     m_stat_reg, m_stat_next;

    assign s_ch   = s_tdata[CH_W-1:0];
    assign s_val  = s_tdata[CH_W +: VAL_W];
    assign s_port = s_tdata[CH_W + VAL_W];
    assign smp    = s_val[VALUE_BITS-1:0];

    // Enabled channels: mask bit set and channel present in hardware.
    assign mask_ext = 32'(mask_reg) & CH_ALLOW_MASK;
    assign hit      = flag_reg & mask_ext[NUM_CHANNELS-1:0];
    assign hit_ext  = 32'(hit);
    assign ch_ok    = ({1'b0, s_ch} < (CH_W + 1)'(NUM_CHANNELS)) && mask_ext[s_ch];

    assign addr_ch = cmd.scan ? cmd.scan_ch : s_ch;
    assign addr    = addr_ch[IDX_W-1:0];
    assign pub_rd  = pub_reg[addr];
    assign idle_rd = idle_reg[addr];

    always_comb begin
        if (smp >= pub_rd) begin
            diff = smp - pub_rd;
        end else begin
            diff = pub_rd - smp;
        end
        band = ((idle_db_reg != '0) && (idle_rd == '0)) ? idle_db_reg : db_reg;
        publish = VAL_W'(diff) > band;
    end

    assign sts.any_hit  = |hit;
    assign sts.cur_hit  = hit_ext[cmd.scan_ch];
    assign sts.more_hit = |((hit_ext >> cmd.scan_ch) >> 1);
    assign sts.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            db_reg          <= '0;
            idle_db_reg     <= '0;
            idle_reload_reg <= '0;
            mask_reg        <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEADBAND:    db_reg          <= cfg_wdata[VAL_W-1:0];
                CFG_IDLE_BAND:   idle_db_reg     <= cfg_wdata[VAL_W-1:0];
                CFG_IDLE_RELOAD: idle_reload_reg <= cfg_wdata[VAL_W-1:0];
                CFG_CH_MASK:     mask_reg        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                pub_reg[i]  <= '0;
                idle_reg[i] <= '0;
            end
            flag_reg <= '0;
        end else begin
            if (cmd.smp_upd && ch_ok) begin
                if (publish) begin
                    pub_reg[addr]  <= smp;
                    flag_reg[addr] <= 1'b1;
                    idle_reg[addr] <= idle_reload_reg;
                end else if (idle_rd != '0) begin
                    idle_reg[addr] <= idle_rd - 1'b1;
                end
            end
            if (cmd.flag_clr) begin
                flag_reg[addr] <= 1'b0;
            end
        end
    end

    always_comb begin
        m_ch_next   = '0;
        m_val_next  = '0;
        m_stat_next = STAT_NONE;
        case (cmd.out_sel)
            SEL_READ: begin
                m_ch_next = s_ch;
                if (!s_port && ch_ok) begin
                    m_val_next  = VAL_W'(pub_rd);
                    m_stat_next = STAT_OK;
                end else begin
                    m_stat_next = STAT_ERR;
                end
            end
            SEL_SCAN: begin
                m_ch_next   = cmd.scan_ch;
                m_val_next  = VAL_W'(pub_rd);
                m_stat_next = STAT_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_ch_reg   <= m_ch_next;
            m_val_reg  <= m_val_next;
            m_stat_reg <= m_stat_next;
            m_last_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_val_reg, m_ch_reg});
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/adc_deadband_change_tracker.sv =====
// Timing: a sample word updates its channel in the cycle it is taken; a read
//   result appears in the output register in the cycle after acceptance.
// Throughput: one sample word per cycle while the output is free; a service
//   word scans one channel per cycle, holding on a flagged channel while the
//   output stalls, and blocks input until its last result.
// Reset: synchronous, active low; clears configuration and all channel stores at once.
`timescale 1ns / 1ps

// Top level of the deadband change tracker.
// Depends on adbct_pkg, adbct_ctrl and adbct_dp.
module adc_deadband_change_tracker #(
    parameter int NUM_CHANNELS = 19,   // channels kept in the stores, 1..32
    parameter int VALUE_BITS   = 16    // stored sample width, 12..16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [adbct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adbct_pkg::CFG_W-1:0]     cfg_wdata,
    // input word stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [adbct_pkg::S_TDATA_W-1:0] s_tdata,  // channel, sample_value, adc_port, pad
    input  logic [adbct_pkg::FUNC_W-1:0]    s_tuser,  // func
    // result word stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [adbct_pkg::M_TDATA_W-1:0] m_tdata,  // out_channel, out_value, pad
    output logic [adbct_pkg::STAT_W-1:0]    m_tuser,  // status
    output logic                            m_tlast
);
    import adbct_pkg::*;

    adbct_cmd_t cmd;
    adbct_sts_t sts;

    // Controller: accept words, drive the service scan.
    adbct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: stores, band compare, output register.
    adbct_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/adbct_checker.sv =====
// Port-level checks of the deadband change tracker, bound to the top level.
// Depends on adbct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adbct_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [adbct_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [adbct_pkg::STAT_W-1:0]    m_tuser,
    input logic                            m_tlast
);
    import adbct_pkg::*;

    `ADBCT_ASSERT_ALWAYS(a_rst_clears_out, !aresetn |=> !m_tvalid, "output word valid after reset")

    `ADBCT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output word changed")

    `ADBCT_ASSERT(a_none_word, m_tvalid && (m_tuser == STAT_NONE) |-> m_tlast && (m_tdata == '0), "bad nothing-changed word")

    `ADBCT_ASSERT(a_err_word, m_tvalid && (m_tuser == STAT_ERR) |-> m_tlast && (m_tdata[M_TDATA_W-1:CH_W] == '0), "bad error word")

    `ADBCT_ASSERT(a_scan_blocks_in, m_tvalid && !m_tlast |-> !s_tready, "input taken inside a service run")

endmodule

bind adc_deadband_change_tracker adbct_checker u_adbct_checker (.*);
